>>> rtl/bwss_pkg.sv
// ----------------------------------------------------------------------------
// bwss_pkg
// Shared types and constants of the best window sum search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bwss_pkg;

   // default sizes of the score table and the day ring
   localparam int DEF_NUM_CATEGORIES = 256;
   localparam int DEF_MAX_DAYS       = 512;

   // field widths of the beats
   localparam int ID_W        = 8;
   localparam int SCORE_W     = 16;
   localparam int START_W     = 10;
   localparam int BSUM_W      = 24;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   // configuration port
   localparam int WLEN_W      = 10;
   localparam int CCOUNT_W    = 9;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [WLEN_W-1:0]   WLEN_RESET   = 10'd1;
   localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 9'd256;
   localparam logic [BSUM_W-1:0]   BSUM_MAX     = 24'hFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH  = 1'b0,
      CSR_CATEGORY_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DAY  = 1'b1
   } cmd_type;

   // control of a day beat in the accumulate stage
   typedef struct packed {
      logic valid;       // a day beat sits in the stage
      logic counted;     // day is scored and enters the ring
      logic sub;         // oldest ring entry leaves the window
      logic full;        // a complete window ends on this day
      logic last;        // end of plan, result goes out
      logic too_long;    // no full window fitted
      logic zero_score;  // category id beyond the table
      logic fwd;         // ring entry is being written by the day ahead
   } s1_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/bwss_ram.sv
// ----------------------------------------------------------------------------
// bwss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bwss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/bwss_front.sv
// ----------------------------------------------------------------------------
// bwss_front
// Accept stage: table clearing pass, score loads, ring pointer and day count,
// memory read issue and the control register of the accumulate stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bwss_front #(
   parameter int NUM_CATEGORIES = bwss_pkg::DEF_NUM_CATEGORIES,
   parameter int MAX_DAYS       = bwss_pkg::DEF_MAX_DAYS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_cmd,
   input  wire logic [bwss_pkg::ID_W-1:0]         req_id,
   input  wire logic [bwss_pkg::SCORE_W-1:0]      req_score,
   input  wire logic                              req_last,
   output logic                                   req_ready,
   input  wire logic [bwss_pkg::WLEN_W-1:0]       win_len,
   input  wire logic [bwss_pkg::CCOUNT_W-1:0]     cat_count,
   input  wire logic                              stall,
   output logic                                   tbl_wr_en,
   output logic [$clog2(NUM_CATEGORIES)-1:0]      tbl_wr_addr,
   output logic [bwss_pkg::SCORE_W-1:0]           tbl_wr_data,
   output logic                                   tbl_rd_en,
   output logic [$clog2(NUM_CATEGORIES)-1:0]      tbl_rd_addr,
   output logic                                   ring_rd_en,
   output logic [$clog2(MAX_DAYS)-1:0]            ring_rd_addr,
   output bwss_pkg::s1_ctrl_type                  s1_ctrl,
   output logic [$clog2(MAX_DAYS)-1:0]            s1_pos,
   output logic [$clog2(MAX_DAYS+1)-1:0]          s1_start
);

   localparam int CAT_W = $clog2(NUM_CATEGORIES);
   localparam int RP_W  = $clog2(MAX_DAYS);
   localparam int DC_W  = $clog2(MAX_DAYS + 1);
   localparam int CW0   = (DC_W > bwss_pkg::WLEN_W) ? DC_W : bwss_pkg::WLEN_W;
   localparam int CW    = ((CW0 > RP_W + 1) ? CW0 : RP_W + 1) + 1;

   logic                  clr_active_ff, clr_active_in;
   logic [CAT_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [RP_W-1:0]       ring_pos_ff, ring_pos_in;
   logic [DC_W-1:0]       day_count_ff, day_count_in;
   bwss_pkg::s1_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   logic [RP_W-1:0]       s1_pos_ff, s1_pos_in;
   logic [DC_W-1:0]       s1_start_ff, s1_start_in;

   logic            accept, is_day, fits, counted, full, too_long, id_ok, load_ok;
   logic [CW-1:0]   len_w, dc_w, pos_w, max_w, pos_inc_w, dc_next_w, dc_after_w;
   logic [RP_W-1:0] pos0, pos_next;
   logic [DC_W-1:0] dc_next, start;

   always_comb begin
      req_ready  = !clr_active_ff && !stall;
      accept     = req_valid && req_ready;
      is_day     = (req_cmd == bwss_pkg::CMD_DAY);

      len_w      = CW'(win_len);
      dc_w       = CW'(day_count_ff);
      pos_w      = CW'(ring_pos_ff);
      max_w      = CW'(MAX_DAYS);
      fits       = (win_len != '0) && (len_w <= max_w);
      counted    = fits && (dc_w < max_w);

      // pointer wraps if the window was shortened
      pos0       = ((pos_w >= len_w) || (pos_w >= max_w)) ? '0 : ring_pos_ff;
      pos_inc_w  = CW'(pos0) + CW'(1);
      pos_next   = (pos_inc_w >= len_w) ? '0 : RP_W'(pos_inc_w);

      dc_next    = day_count_ff + DC_W'(1);
      dc_next_w  = CW'(dc_next);
      full       = (dc_next_w >= len_w);
      start      = DC_W'(dc_next_w - len_w + CW'(1));
      dc_after_w = counted ? dc_next_w : dc_w;
      too_long   = !fits || (dc_after_w < len_w);

      id_ok      = (32'(req_id) < 32'(NUM_CATEGORIES));
      load_ok    = id_ok && ({1'b0, req_id} < cat_count);
   end

   // table write port: clearing pass after reset, then score loads
   always_comb begin
      if (clr_active_ff) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = clr_addr_ff;
         tbl_wr_data = '0;
      end else begin
         tbl_wr_en   = accept && !is_day && load_ok;
         tbl_wr_addr = CAT_W'(req_id);
         tbl_wr_data = req_score;
      end
      tbl_rd_en    = accept && is_day && id_ok;
      tbl_rd_addr  = CAT_W'(req_id);
      ring_rd_en   = accept && is_day && counted;
      ring_rd_addr = pos0;
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + CAT_W'(1);
         if (clr_addr_ff == CAT_W'(NUM_CATEGORIES - 1)) begin
            clr_active_in = 1'b0;
         end
      end

      ring_pos_in  = ring_pos_ff;
      day_count_in = day_count_ff;
      if (accept && is_day) begin
         if (req_last) begin
            ring_pos_in  = '0;
            day_count_in = '0;
         end else if (counted) begin
            ring_pos_in  = pos_next;
            day_count_in = dc_next;
         end
      end

      s1_ctrl_in  = s1_ctrl_ff;
      s1_pos_in   = s1_pos_ff;
      s1_start_in = s1_start_ff;
      if (!stall) begin
         s1_ctrl_in.valid      = accept && is_day;
         s1_ctrl_in.counted    = counted;
         s1_ctrl_in.sub        = (dc_w >= len_w);
         s1_ctrl_in.full       = full;
         s1_ctrl_in.last       = req_last;
         s1_ctrl_in.too_long   = too_long;
         s1_ctrl_in.zero_score = !id_ok;
         // the entry is written by the day leaving the stage at this edge
         s1_ctrl_in.fwd        = s1_ctrl_ff.valid && s1_ctrl_ff.counted &&
                                 (s1_pos_ff == pos0);
         s1_pos_in             = pos0;
         s1_start_in           = start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         ring_pos_ff   <= '0;
         day_count_ff  <= '0;
         s1_ctrl_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         ring_pos_ff   <= ring_pos_in;
         day_count_ff  <= day_count_in;
         s1_ctrl_ff    <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff   <= s1_pos_in;
      s1_start_ff <= s1_start_in;
   end

   assign s1_ctrl  = s1_ctrl_ff;
   assign s1_pos   = s1_pos_ff;
   assign s1_start = s1_start_ff;

   a_day_count_range : assert property (@(posedge clock) disable iff (reset)
      32'(day_count_ff) <= 32'(MAX_DAYS))
      else $error("day count beyond ring depth");

   a_plan_restart : assert property (@(posedge clock) disable iff (reset)
      (accept && is_day && req_last) |=> (day_count_ff == '0 && ring_pos_ff == '0))
      else $error("run state not cleared after last day");

   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !(tbl_rd_en || ring_rd_en || s1_ctrl_in.valid))
      else $error("day accepted during table clearing");

endmodule

`default_nettype wire

>>> rtl/bwss_accum.sv
// ----------------------------------------------------------------------------
// bwss_accum
// Accumulate stage: running window sum, best window tracking, ring write back
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bwss_accum #(
   parameter int MAX_DAYS = bwss_pkg::DEF_MAX_DAYS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bwss_pkg::s1_ctrl_type             s1_ctrl,
   input  wire logic [$clog2(MAX_DAYS)-1:0]       s1_pos,
   input  wire logic [$clog2(MAX_DAYS+1)-1:0]     s1_start,
   input  wire logic [bwss_pkg::SCORE_W-1:0]      tbl_rd_data,
   input  wire logic [bwss_pkg::SCORE_W-1:0]      ring_rd_data,
   output logic                                   stall,
   output logic                                   ring_wr_en,
   output logic [$clog2(MAX_DAYS)-1:0]            ring_wr_addr,
   output logic [bwss_pkg::SCORE_W-1:0]           ring_wr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bwss_pkg::START_W-1:0]           best_start,
   output logic [bwss_pkg::BSUM_W-1:0]            best_sum,
   output logic                                   window_too_long
);

   localparam int DC_W  = $clog2(MAX_DAYS + 1);
   localparam int SUM_W = bwss_pkg::SCORE_W + $clog2(MAX_DAYS);

   logic signed [SUM_W-1:0]            running_ff, running_in;
   logic signed [SUM_W-1:0]            best_total_ff, best_total_in;
   logic [DC_W-1:0]                    best_day_ff, best_day_in;
   logic signed [bwss_pkg::SCORE_W-1:0] fwd_data_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bwss_pkg::START_W-1:0]       best_start_ff, best_start_in;
   logic [bwss_pkg::BSUM_W-1:0]        best_sum_ff, best_sum_in;
   logic                               too_long_ff, too_long_in;

   logic                                advance, step, better;
   logic signed [bwss_pkg::SCORE_W-1:0] s_cur, old;
   logic signed [SUM_W-1:0]             sum_step, best_post;
   logic [DC_W-1:0]                     day_post;
   logic signed [31:0]                  best_w;

   always_comb begin
      stall     = s1_ctrl.valid && s1_ctrl.last && rsp_valid_ff && !rsp_ready;
      advance   = !stall;
      step      = s1_ctrl.valid && s1_ctrl.counted;

      s_cur     = s1_ctrl.zero_score ? '0 : $signed(tbl_rd_data);
      old       = s1_ctrl.fwd ? fwd_data_ff : $signed(ring_rd_data);
      sum_step  = running_ff - (s1_ctrl.sub ? SUM_W'(old) : '0) + SUM_W'(s_cur);

      // strictly greater keeps the earliest start
      better    = step && s1_ctrl.full && (sum_step > best_total_ff);
      best_post = better ? sum_step : best_total_ff;
      day_post  = better ? s1_start : best_day_ff;

      best_w    = 32'(best_post);

      ring_wr_en   = advance && step;
      ring_wr_addr = s1_pos;
      ring_wr_data = s_cur;
   end

   always_comb begin
      running_in    = running_ff;
      best_total_in = best_total_ff;
      best_day_in   = best_day_ff;
      if (advance && s1_ctrl.valid) begin
         if (s1_ctrl.last) begin
            running_in    = '0;
            best_total_in = '0;
            best_day_in   = DC_W'(1);
         end else begin
            running_in    = step ? sum_step : running_ff;
            best_total_in = best_post;
            best_day_in   = day_post;
         end
      end

      rsp_valid_in  = rsp_valid_ff;
      best_start_in = best_start_ff;
      best_sum_in   = best_sum_ff;
      too_long_in   = too_long_ff;
      if (advance && s1_ctrl.valid && s1_ctrl.last) begin
         rsp_valid_in  = 1'b1;
         best_start_in = bwss_pkg::START_W'(day_post);
         if (best_w < 32'sd0) begin
            best_sum_in = '0;
         end else if (best_w > 32'(bwss_pkg::BSUM_MAX)) begin
            best_sum_in = bwss_pkg::BSUM_MAX;
         end else begin
            best_sum_in = best_w[bwss_pkg::BSUM_W-1:0];
         end
         too_long_in   = s1_ctrl.too_long;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         best_total_ff <= '0;
         best_day_ff   <= DC_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         running_ff    <= running_in;
         best_total_ff <= best_total_in;
         best_day_ff   <= best_day_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_data_ff <= s_cur;
      end
      best_start_ff <= best_start_in;
      best_sum_ff   <= best_sum_in;
      too_long_ff   <= too_long_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign best_start      = best_start_ff;
   assign best_sum        = best_sum_ff;
   assign window_too_long = too_long_ff;

   a_best_nonneg : assert property (@(posedge clock) disable iff (reset)
      best_total_ff >= 0)
      else $error("best total went negative");

   a_result_issued : assert property (@(posedge clock) disable iff (reset)
      (s1_ctrl.valid && s1_ctrl.last && !stall) |=> rsp_valid_ff)
      else $error("last day left the stage without a result");

   a_no_ring_write_in_stall : assert property (@(posedge clock) disable iff (reset)
      stall |-> !ring_wr_en)
      else $error("ring written while stage held");

endmodule

`default_nettype wire

>>> rtl/best_window_sum_search_unit.sv
// ----------------------------------------------------------------------------
// best_window_sum_search_unit
// Fixed length sliding window over daily category scores; reports the
// earliest window start with the greatest sum at the end of each plan.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Beat contents (low bits first)
//  --------+--------------------------------+--------------------------------------
//  req     | req_tvalid/tready/tdata/tuser/ | tdata: category_id, score_value
//          | tlast                          | tuser: cmd (load / day), tlast: last_day
//  rsp     | rsp_tvalid/tready/tdata/tuser  | tdata: best_start, best_sum
//          |                                | tuser: window_too_long
//  csr     | csr_valid/ready/index/wdata    | index 0 window_length, 1 category_count
//
//  One req beat per cycle while req_tready is high, loads and days alike, bounded
//  by the one read port of each RAM. A last-day beat passes the accumulate stage
//  control register, then its result is registered in rsp. After reset a
//  clearing pass zeroes the score table; req_tready stays low meanwhile, csr
//  writes are taken as ever. Apart from that pass, req_tready drops only while a
//  result waits in rsp and another last day has reached the accumulate stage.
//
`default_nettype none

module best_window_sum_search_unit #(
   parameter int NUM_CATEGORIES = bwss_pkg::DEF_NUM_CATEGORIES,
   parameter int MAX_DAYS       = bwss_pkg::DEF_MAX_DAYS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bwss_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [7:0] category_id,
                                                              // [23:8] score_value
   input  wire logic                              req_tuser,  // [0] cmd
   input  wire logic                              req_tlast,  // last_day
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bwss_pkg::RSP_TDATA_W-1:0]       rsp_tdata,  // [9:0] best_start,
                                                              // [33:10] best_sum, rest 0
   output logic                                   rsp_tuser,  // [0] window_too_long
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bwss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bwss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CAT_W = $clog2(NUM_CATEGORIES);
   localparam int RP_W  = $clog2(MAX_DAYS);
   localparam int DC_W  = $clog2(MAX_DAYS + 1);

   // configuration registers
   logic [bwss_pkg::WLEN_W-1:0]   win_len_ff, win_len_in;
   logic [bwss_pkg::CCOUNT_W-1:0] cat_count_ff, cat_count_in;

   // score table ports
   logic                          tbl_wr_en, tbl_rd_en;
   logic [CAT_W-1:0]              tbl_wr_addr, tbl_rd_addr;
   logic [bwss_pkg::SCORE_W-1:0]  tbl_wr_data, tbl_rd_data;

   // day ring ports
   logic                          ring_wr_en, ring_rd_en;
   logic [RP_W-1:0]               ring_wr_addr, ring_rd_addr;
   logic [bwss_pkg::SCORE_W-1:0]  ring_wr_data, ring_rd_data;

   // accept stage to accumulate stage
   bwss_pkg::s1_ctrl_type         s1_ctrl;
   logic [RP_W-1:0]               s1_pos;
   logic [DC_W-1:0]               s1_start;
   logic                          stall;

   logic [bwss_pkg::START_W-1:0]  best_start;
   logic [bwss_pkg::BSUM_W-1:0]   best_sum;
   logic                          window_too_long;

   // registers are always writable
   assign csr_ready = 1'b1;

   always_comb begin
      win_len_in   = win_len_ff;
      cat_count_in = cat_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bwss_pkg::CSR_WINDOW_LENGTH: begin
               win_len_in = csr_wdata[bwss_pkg::WLEN_W-1:0];
            end
            bwss_pkg::CSR_CATEGORY_COUNT: begin
               cat_count_in = csr_wdata[bwss_pkg::CCOUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff   <= bwss_pkg::WLEN_RESET;
         cat_count_ff <= bwss_pkg::CCOUNT_RESET;
      end else begin
         win_len_ff   <= win_len_in;
         cat_count_ff <= cat_count_in;
      end
   end

   bwss_front #(
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .MAX_DAYS       (MAX_DAYS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_cmd      (req_tuser),
      .req_id       (req_tdata[7:0]),
      .req_score    (req_tdata[23:8]),
      .req_last     (req_tlast),
      .req_ready    (req_tready),
      .win_len      (win_len_ff),
      .cat_count    (cat_count_ff),
      .stall        (stall),
      .tbl_wr_en    (tbl_wr_en),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_data  (tbl_wr_data),
      .tbl_rd_en    (tbl_rd_en),
      .tbl_rd_addr  (tbl_rd_addr),
      .ring_rd_en   (ring_rd_en),
      .ring_rd_addr (ring_rd_addr),
      .s1_ctrl      (s1_ctrl),
      .s1_pos       (s1_pos),
      .s1_start     (s1_start)
   );

   // score per category id
   bwss_ram #(
      .WIDTH (bwss_pkg::SCORE_W),
      .DEPTH (NUM_CATEGORIES)
   ) u_score_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // scores of the days inside the current window
   bwss_ram #(
      .WIDTH (bwss_pkg::SCORE_W),
      .DEPTH (MAX_DAYS)
   ) u_window_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   bwss_accum #(
      .MAX_DAYS (MAX_DAYS)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .s1_ctrl         (s1_ctrl),
      .s1_pos          (s1_pos),
      .s1_start        (s1_start),
      .tbl_rd_data     (tbl_rd_data),
      .ring_rd_data    (ring_rd_data),
      .stall           (stall),
      .ring_wr_en      (ring_wr_en),
      .ring_wr_addr    (ring_wr_addr),
      .ring_wr_data    (ring_wr_data),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .best_start      (best_start),
      .best_sum        (best_sum),
      .window_too_long (window_too_long)
   );

   assign rsp_tdata = {6'b0, best_sum, best_start};
   assign rsp_tuser = window_too_long;

endmodule

`default_nettype wire
